// ----- hdl/sorted_unique_set_top_defines.svh -----
// Assertion macros shared by the sorted set RTL
`ifndef SORTED_UNIQUE_SET_TOP_DEFINES_SVH
`define SORTED_UNIQUE_SET_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define SUS_ASSERT_ALWAYS(name, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("sorted set assertion failed");

`define SUS_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted set assertion failed");

`define SUS_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted set assertion failed");

`else

`define SUS_ASSERT_ALWAYS(name, expr)
`define SUS_ASSERT_SAME(name, ante, cons)
`define SUS_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ----- hdl/sus_pkg.sv -----
// Types and constants of the sorted set block
package sus_pkg;

   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_REMOVED   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd4;

   typedef struct packed {
      logic load;
      logic compare;
      logic commit;
   } cmd_type;

endpackage

// ----- hdl/sus_ctrl.sv -----
// Sequencer of the sorted set: accept, compare, commit and result handshake
`include "sorted_unique_set_top_defines.svh"

module sus_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sus_pkg::cmd_type cmd
);
   import sus_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CMP  = 2'd1;
   localparam logic [1:0] ST_UPD  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;
   logic       accept;
   logic       commit;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == ST_UPD) && out_free;
   assign req_ready = (state_ff == ST_IDLE) || commit;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   assign cmd.load    = accept;
   assign cmd.compare = (state_ff == ST_CMP);
   assign cmd.commit  = commit;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_CMP;
         end
         ST_CMP: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (commit) state_in = accept ? ST_CMP : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `SUS_ASSERT_NEXT(a_accept_to_cmp, accept, state_ff == ST_CMP)
   `SUS_ASSERT_NEXT(a_cmp_to_upd, state_ff == ST_CMP, state_ff == ST_UPD)
   `SUS_ASSERT_NEXT(a_commit_shows_rsp, commit, rsp_valid_ff)

endmodule

// ----- hdl/sus_dpath.sv -----
// Datapath of the sorted set: row of value cells with parallel compare and shift
`include "sorted_unique_set_top_defines.svh"

module sus_dpath #(
   parameter  int CAPACITY = 16,
   localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sus_pkg::cmd_type                       cmd,
   input  logic                                   req_func,
   input  logic signed [sus_pkg::VALUE_W-1:0]     req_value,
   output logic        [sus_pkg::STATUS_W-1:0]    rsp_status,
   output logic        [sus_pkg::COUNT_W-1:0]     rsp_count
);
   import sus_pkg::*;

   logic                      func_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] entry_ff [CAPACITY];
   logic signed [VALUE_W-1:0] entry_in [CAPACITY];
   logic [CAPACITY-1:0]       occ_ff;
   logic [CAPACITY-1:0]       occ_in;
   logic [CAPACITY-1:0]       lt_ff;
   logic [CAPACITY-1:0]       lt_in;
   logic [CAPACITY-1:0]       eq_ff;
   logic [CAPACITY-1:0]       eq_in;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic [STATUS_W-1:0]       status_ff;
   logic [STATUS_W-1:0]       status_in;
   logic                      hit;
   logic                      full;
   logic                      do_ins;
   logic                      do_rem;

   assign hit    = |eq_ff;
   assign full   = occ_ff[CAPACITY-1];
   assign do_ins = cmd.commit && (func_ff == FUNC_INSERT) && !hit && !full;
   assign do_rem = cmd.commit && (func_ff == FUNC_REMOVE) && hit;

   always_comb begin
      priority if (func_ff == FUNC_REMOVE) begin
         status_in = hit ? STATUS_REMOVED : STATUS_NOT_FOUND;
      end else if (hit) begin
         status_in = STATUS_DUPLICATE;
      end else if (full) begin
         status_in = STATUS_FULL;
      end else begin
         status_in = STATUS_INSERTED;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_ins) count_in = count_ff + CNT_W'(1);
      else if (do_rem) count_in = count_ff - CNT_W'(1);
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] prev_val;
      logic signed [VALUE_W-1:0] next_val;
      logic                      at_pos;
      logic                      prev_occ;
      logic                      next_occ;

      if (i == 0) begin : g_first
         assign prev_val = value_ff;
         assign at_pos   = 1'b1;
         assign prev_occ = 1'b1;
      end else begin : g_rest
         assign prev_val = entry_ff[i-1];
         assign at_pos   = lt_ff[i-1];
         assign prev_occ = occ_ff[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_val = entry_ff[i];
         assign next_occ = 1'b0;
      end else begin : g_inner
         assign next_val = entry_ff[i+1];
         assign next_occ = occ_ff[i+1];
      end

      assign lt_in[i] = occ_ff[i] && (entry_ff[i] < value_ff);
      assign eq_in[i] = occ_ff[i] && (entry_ff[i] == value_ff);

      always_comb begin
         entry_in[i] = entry_ff[i];
         occ_in[i]   = occ_ff[i];
         if (do_ins) begin
            occ_in[i] = prev_occ;
            if (!lt_ff[i]) entry_in[i] = at_pos ? value_ff : prev_val;
         end else if (do_rem) begin
            occ_in[i] = next_occ;
            if (!lt_ff[i]) entry_in[i] = next_val;
         end
      end

      always_ff @(posedge clock) begin
         entry_ff[i] <= entry_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         value_ff <= req_value;
      end
      if (cmd.compare) begin
         lt_ff <= lt_in;
         eq_ff <= eq_in;
      end
      if (cmd.commit) status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff   <= '0;
         count_ff <= '0;
      end else begin
         occ_ff   <= occ_in;
         count_ff <= count_in;
      end
   end

   assign rsp_count  = COUNT_W'(count_ff);
   assign rsp_status = status_ff;

   `SUS_ASSERT_ALWAYS(a_occ_matches_count, $countones(occ_ff) == count_ff)
   `SUS_ASSERT_NEXT(a_insert_grows, do_ins, count_ff == $past(count_ff) + CNT_W'(1))
   `SUS_ASSERT_SAME(a_no_dual_update, do_ins || do_rem, !(do_ins && do_rem))

endmodule

// ----- hdl/sorted_unique_set_top.sv -----
// Top level of the sorted set of distinct signed 32-bit values
//
//   channel   direction  ports                              handshake
//   request   in         req_func, req_value                req_valid / req_ready
//   response  out        rsp_status, rsp_count              rsp_valid / rsp_ready
//
// A transaction first compares the value against every cell in parallel, then
// shifts the cell row and loads the response register.
// The next transaction is taken in the commit cycle, so a new request is accepted
// while the last one commits, as long as the response side keeps up.
// A response that is not taken holds the commit cycle and stalls the request side.
// Reset is synchronous and empties the set at once; no clearing pass is needed.
module sorted_unique_set_top #(
   parameter int CAPACITY = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic signed [sus_pkg::VALUE_W-1:0]  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic        [sus_pkg::STATUS_W-1:0] rsp_status,
   output logic        [sus_pkg::COUNT_W-1:0]  rsp_count
);
   import sus_pkg::*;

   cmd_type cmd;

   sus_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   sus_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_func   (req_func),
      .req_value  (req_value),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count)
   );

endmodule

// ----- bench/tb_top.sv -----
// Testbench for the sorted set block: scoreboard class, request driver, response checker
module tb_top;
   import sus_pkg::*;

   localparam int CAPACITY    = 16;
   localparam int ITEMS       = 800;
   localparam int SEGMENT     = 100;
   localparam int LONG_HOLD   = 200;
   localparam int POOL_SIZE   = 24;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } outcome_type;

   class set_scoreboard;
      logic signed [VALUE_W-1:0] cells [CAPACITY];
      int                        stored;
      outcome_type               pending_outcomes [$];
      int                        failures;
      int                        reported;

      function new();
         stored   = 0;
         failures = 0;
         reported = 0;
      endfunction

      function void note_request(logic func, logic signed [VALUE_W-1:0] value);
         int                  pos;
         logic [STATUS_W-1:0] st;
         outcome_type         o;
         pos = 0;
         while (pos < stored && cells[pos] < value)
            pos++;
         if (func == FUNC_INSERT) begin
            if (pos < stored && cells[pos] == value) begin
               st = STATUS_DUPLICATE;
            end else if (stored >= CAPACITY) begin
               st = STATUS_FULL;
            end else begin
               for (int k = stored; k > pos; k--)
                  cells[k] = cells[k-1];
               cells[pos] = value;
               stored++;
               st = STATUS_INSERTED;
            end
         end else begin
            if (pos >= stored || cells[pos] != value) begin
               st = STATUS_NOT_FOUND;
            end else begin
               for (int k = pos; k + 1 < stored; k++)
                  cells[k] = cells[k+1];
               stored--;
               st = STATUS_REMOVED;
            end
         end
         o.status = st;
         o.count  = stored[COUNT_W-1:0];
         pending_outcomes.push_back(o);
      endfunction

      function void check_response(logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] count);
         outcome_type want;
         if (pending_outcomes.size() == 0) begin
            failures++;
            if (reported < 10) begin
               reported++;
               $display("unexpected response: status %0d count %0d", status, count);
            end
            return;
         end
         want = pending_outcomes.pop_front();
         if (status !== want.status || count !== want.count) begin
            failures++;
            if (reported < 10) begin
               reported++;
               $display("response mismatch: status %0d (expected %0d) count %0d (expected %0d)",
                        status, want.status, count, want.count);
            end
         end
      endfunction
   endclass

   logic                         clock     = 1'b0;
   logic                         reset     = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_func  = FUNC_INSERT;
   logic signed [VALUE_W-1:0]    req_value = '0;
   logic                         rsp_ready = 1'b0;
   logic                         req_ready;
   logic                         rsp_valid;
   logic        [STATUS_W-1:0]   rsp_status;
   logic        [COUNT_W-1:0]    rsp_count;

   set_scoreboard                sb;
   bit                           quiet = 1'b0;
   int                           rsp_hold_request = 0;
   int                           cycles = 0;
   logic signed [VALUE_W-1:0]    pool [POOL_SIZE];

   sorted_unique_set_top #(.CAPACITY(CAPACITY)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_func   (req_func),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_status, rsp_count);
   end

   // response side: random stalls, plus one long hold on request
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request > 0) begin
            hold_left        = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0 && !quiet) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ready  <= 1'b0;
            stall_left = $urandom_range(1, 8) - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_item(logic func, logic signed [VALUE_W-1:0] value);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      sb.note_request(func, value);
   endtask

   task automatic fill_pool();
      pool[0] = 32'sh8000_0000;
      pool[1] = 32'sh7FFF_FFFF;
      pool[2] = 32'sd0;
      pool[3] = -32'sd1;
      for (int i = 4; i < POOL_SIZE; i++)
         pool[i] = (i < 12) ? $signed($urandom_range(0, 40)) - 32'sd20 : $signed($urandom);
   endtask

   initial begin
      logic                      func;
      logic signed [VALUE_W-1:0] value;
      int                        seg;
      int                        insert_pct;
      sb = new();
      fill_pool();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_item(FUNC_REMOVE, 32'sd5);
      send_item(FUNC_INSERT, 32'sh7FFF_FFFF);
      send_item(FUNC_INSERT, 32'sh8000_0000);
      send_item(FUNC_INSERT, 32'sd0);
      send_item(FUNC_INSERT, -32'sd1);
      send_item(FUNC_INSERT, 32'sh7FFF_FFFF);
      send_item(FUNC_REMOVE, 32'sd5);
      for (int k = 0; k < CAPACITY - 4; k++)
         send_item(FUNC_INSERT, 32'sd100 * k - 32'sd550);
      send_item(FUNC_INSERT, 32'sd7777);
      send_item(FUNC_INSERT, 32'sd0);
      send_item(FUNC_REMOVE, 32'sh8000_0000);
      send_item(FUNC_REMOVE, 32'sh7FFF_FFFF);
      send_item(FUNC_REMOVE, 32'sd12345);
      send_item(FUNC_INSERT, 32'sh5555_AAAA);

      for (int n = 0; n < ITEMS; n++) begin
         seg = n / SEGMENT;
         if (n % SEGMENT == 0) begin
            quiet = (seg == 3 || seg == 7);
            if (seg == 2)
               rsp_hold_request = LONG_HOLD;
            if (seg == 4)
               fill_pool();
            if (seg == 5) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (sb.pending_outcomes.size() != 0);
            end
         end
         insert_pct = (seg % 2 == 0) ? 75 : 25;
         func  = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
         value = ($urandom_range(0, 6) == 0) ? $signed($urandom)
                                             : pool[$urandom_range(0, POOL_SIZE - 1)];
         send_item(func, value);
      end

      req_valid <= 1'b0;
      while (sb.pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.failures == 0 && sb.pending_outcomes.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
